// File: hdl/cwbm_pkg.sv
// shared types and constants for the copper wait beam compare block
`default_nettype none
package cwbm_pkg;

	localparam int unsigned LINE_W   = 9;
	localparam int unsigned CYCLE_W  = 8;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [LINE_W-1:0]  LINES_RESET  = 9'd313;
	localparam logic [CYCLE_W-1:0] CYCLES_RESET = 8'd227;

	// register index, taken from paddr bit 2
	localparam logic REG_LINES  = 1'b0;
	localparam logic REG_CYCLES = 1'b1;

	// cycle positions with special handling
	localparam logic [CYCLE_W-1:0] CYC_HOLE = 8'he2;
	localparam logic [CYCLE_W-1:0] CYC_WRAP = 8'he0;

	typedef struct packed {
		logic [LINE_W-1:0]  lines_in_frame;
		logic [CYCLE_W-1:0] cycles_in_line;
	} cfg_t;

	typedef struct packed {
		logic [7:0] op;
		logic [7:0] tgt;
		logic [7:0] msk;
	} cmp_req_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage
`default_nettype wire

// File: hdl/cwbm_in_if.sv
// input channel: one wait/skip instruction pair and the beam position
`default_nettype none
interface cwbm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] first_word;
	logic [15:0] second_word;
	logic [8:0]  current_line;
	logic [7:0]  current_cycle;

	modport source (output valid, output first_word, output second_word,
		output current_line, output current_cycle, input ready);
	modport sink (input valid, input first_word, input second_word,
		input current_line, input current_cycle, output ready);
endinterface
`default_nettype wire

// File: hdl/cwbm_out_if.sv
// output channel: skip test and wakeup position
`default_nettype none
interface cwbm_out_if;
	logic       valid;
	logic       ready;
	logic       passed_now;
	logic       wake_found;
	logic [8:0] wake_line;
	logic [7:0] wake_cycle;

	modport source (output valid, output passed_now, output wake_found,
		output wake_line, output wake_cycle, input ready);
	modport sink (input valid, input passed_now, input wake_found,
		input wake_line, input wake_cycle, output ready);
endinterface
`default_nettype wire

// File: hdl/cwbm_regs.sv
// apb configuration registers: lines per frame and cycles per line
`default_nettype none
module cwbm_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cwbm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [cwbm_pkg::PDATA_W-1:0]  pwdata,
	output      logic [cwbm_pkg::PDATA_W-1:0]  prdata,
	output      logic                          pready,
	output      cwbm_pkg::cfg_t                cfg
);
	logic [cwbm_pkg::LINE_W-1:0]  lines_q;
	logic [cwbm_pkg::CYCLE_W-1:0] cycles_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q  <= cwbm_pkg::LINES_RESET;
			cycles_q <= cwbm_pkg::CYCLES_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				cwbm_pkg::REG_LINES:  lines_q  <= pwdata[cwbm_pkg::LINE_W-1:0];
				cwbm_pkg::REG_CYCLES: cycles_q <= pwdata[cwbm_pkg::CYCLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cwbm_pkg::REG_LINES:  prdata = {23'd0, lines_q};
			cwbm_pkg::REG_CYCLES: prdata = {24'd0, cycles_q};
			default:              prdata = '0;
		endcase
	end

	assign cfg.lines_in_frame = lines_q;
	assign cfg.cycles_in_line = cycles_q;
endmodule
`default_nettype wire

// File: hdl/cwbm_cmp.sv
// shared masked compare unit for beam line and beam cycle
`default_nettype none
module cwbm_cmp (
	input  wire cwbm_pkg::cmp_req_t req,
	output      cwbm_pkg::cmp_res_t res
);
	logic [7:0] a;
	logic [7:0] b;

	assign a      = req.op & req.msk;
	assign b      = req.tgt & req.msk;
	assign res.lt = a < b;
	assign res.eq = a == b;
	assign res.gt = a > b;
endmodule
`default_nettype wire

// File: hdl/copper_wait_beam_match.sv
// copper wait/skip beam compare: skip test and wakeup search over one frame
// the scan steps the cycle and then the line, one step at a time through the shared compare unit
// throughput: one instruction at a time, next beat taken the cycle after the result loads;
//   the result sits in an output register, so a new item may enter while it waits
// reset (arst_n low, asynchronous): sequencer idle, no result pending, lines_in_frame 313, cycles_in_line 227
`default_nettype none
module copper_wait_beam_match (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cwbm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [cwbm_pkg::PDATA_W-1:0]  pwdata,
	output      logic [cwbm_pkg::PDATA_W-1:0]  prdata,
	output      logic                          pready,
	cwbm_in_if.sink                            in_ch,
	cwbm_out_if.source                         out_ch
);
	// sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_PLINE = 11'b00000000010, // skip test, line compare
		ST_PCYC  = 11'b00000000100, // skip test, cycle compare
		ST_ADV   = 11'b00000001000, // advance the start position past the beam position
		ST_FIRST = 11'b00000010000, // first line compare
		ST_HSCAN = 11'b00000100000, // step the cycle by two
		ST_LSCAN = 11'b00001000000, // step the line by one
		ST_FIXA  = 11'b00010000000, // move cycle 0xe2 forward
		ST_FIXB  = 11'b00100000000, // move the wakeup back ahead of the match
		ST_FIXC  = 11'b01000000000, // cycle 0xe0 wraps to next line
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t             state_q;
	cwbm_pkg::cfg_t     cfg;
	cwbm_pkg::cmp_req_t cmp_req;
	cwbm_pkg::cmp_res_t cmp_res;

	// latched instruction and beam position
	logic [7:0] tv_q, th_q, mv_q, mh_q;
	logic [8:0] cur_line_q;
	logic [7:0] cur_cyc_q;

	// working position, wider than the fields so that wraps are seen
	logic [9:0] wl_q;
	logic [8:0] wc_q;

	logic pgt_q, peq_q, passed_q;
	logic second_q;  // cycle scan runs from cycle 0 of the next line
	logic hfound_q;  // a cycle from 0 reaches the target within the line
	logic found_q;

	// output register
	logic       out_valid_q;
	logic       out_passed_q;
	logic       out_found_q;
	logic [8:0] out_line_q;
	logic [7:0] out_cycle_q;

	logic       in_take;
	logic       out_load;
	logic       in_line;
	logic       in_frame;
	logic       line_step;
	logic [8:0] c_plus2;

	// advance unit shared by the start move and the 0xe2 move
	logic [9:0] adv_line_in;
	logic [8:0] adv_cyc_in;
	logic [8:0] adv_n;
	logic [8:0] adv_sum;
	logic [8:0] adv_sub;
	logic       adv_wrap;
	logic [9:0] adv_line;
	logic [8:0] adv_cyc;

	cwbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cwbm_cmp u_cmp (
		.req (cmp_req),
		.res (cmp_res)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_take     = in_ch.valid & in_ch.ready;
	assign out_load    = (state_q == ST_DONE) & (~out_valid_q | out_ch.ready);

	// compare operand select: cycle compares in the skip cycle test and cycle scan
	always_comb begin
		unique case (state_q)
			ST_PLINE: cmp_req = '{op: cur_line_q[7:0], tgt: tv_q, msk: mv_q};
			ST_PCYC:  cmp_req = '{op: cur_cyc_q, tgt: th_q, msk: mh_q};
			ST_HSCAN: cmp_req = '{op: wc_q[7:0], tgt: th_q, msk: mh_q};
			default:  cmp_req = '{op: wl_q[7:0], tgt: tv_q, msk: mv_q};
		endcase
	end

	// advance: add n, past the line end subtract the line length,
	// bump the line and round an odd cycle up
	always_comb begin
		if (state_q == ST_ADV) begin
			adv_line_in = {1'b0, cur_line_q};
			adv_cyc_in  = {1'b0, cur_cyc_q};
			adv_n       = 9'd2;
		end else begin
			adv_line_in = wl_q;
			adv_cyc_in  = wc_q;
			adv_n       = 9'd1;
		end
		adv_sum  = adv_cyc_in + adv_n;
		adv_wrap = adv_sum >= {1'b0, cfg.cycles_in_line};
		adv_sub  = adv_sum - {1'b0, cfg.cycles_in_line};
		adv_line = adv_wrap ? adv_line_in + 10'd1 : adv_line_in;
		adv_cyc  = adv_wrap ? adv_sub + {8'd0, adv_sub[0]} : adv_sum;
	end

	assign in_line   = wc_q <= {1'b0, cfg.cycles_in_line};
	assign in_frame  = wl_q < {1'b0, cfg.lines_in_frame};
	// with a cycle hit the line scan stops at equal, otherwise it passes equal lines
	assign line_step = in_frame & (hfound_q ? cmp_res.lt : (cmp_res.lt | cmp_res.eq));
	assign c_plus2   = {1'b0, cur_cyc_q} + 9'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_take) state_q <= ST_PLINE;
				ST_PLINE: state_q <= ST_PCYC;
				ST_PCYC:  state_q <= ST_ADV;
				ST_ADV:   state_q <= ST_FIRST;
				ST_FIRST: state_q <= cmp_res.gt ? ST_FIXA : ST_HSCAN;
				ST_HSCAN: begin
					if (!(in_line && cmp_res.lt)) begin
						if (second_q) state_q <= ST_LSCAN;
						else if (in_line) state_q <= ST_FIXA;
					end
				end
				ST_LSCAN: if (!line_step) state_q <= in_frame ? ST_FIXA : ST_DONE;
				ST_FIXA:  state_q <= ST_FIXB;
				ST_FIXB:  state_q <= ST_FIXC;
				ST_FIXC:  state_q <= ST_DONE;
				ST_DONE:  if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					tv_q       <= in_ch.first_word[15:8];
					th_q       <= {in_ch.first_word[7:1], 1'b0};
					mv_q       <= {1'b1, in_ch.second_word[14:8]};
					mh_q       <= {in_ch.second_word[7:1], 1'b0};
					cur_line_q <= in_ch.current_line;
					cur_cyc_q  <= in_ch.current_cycle;
				end
			end
			ST_PLINE: begin
				pgt_q <= cmp_res.gt;
				peq_q <= cmp_res.eq;
			end
			ST_PCYC: passed_q <= pgt_q | (peq_q & ~cmp_res.lt);
			ST_ADV: begin
				wl_q <= adv_line;
				wc_q <= adv_cyc;
			end
			ST_FIRST: begin
				found_q  <= cmp_res.gt;
				hfound_q <= 1'b0;
				if (cmp_res.eq) begin
					second_q <= 1'b0;
				end else if (!cmp_res.gt) begin
					// line not reached: scan from cycle 0 of the next line
					second_q <= 1'b1;
					wl_q     <= wl_q + 10'd1;
					wc_q     <= '0;
				end
			end
			ST_HSCAN: begin
				if (in_line && cmp_res.lt) begin
					wc_q <= wc_q + 9'd2;
				end else if (!second_q) begin
					if (in_line) begin
						found_q <= 1'b1;
					end else begin
						second_q <= 1'b1;
						wl_q     <= wl_q + 10'd1;
						wc_q     <= '0;
					end
				end else begin
					hfound_q <= in_line;
					if (!in_line) wc_q <= '0;
				end
			end
			ST_LSCAN: begin
				if (line_step) begin
					wl_q <= wl_q + 10'd1;
				end else begin
					found_q <= in_frame;
					if (!in_frame) begin
						wl_q <= '0;
						wc_q <= '0;
					end else if (hfound_q && cmp_res.lt) begin
						wc_q <= '0;
					end
				end
			end
			ST_FIXA: begin
				if (wc_q == {1'b0, cwbm_pkg::CYC_HOLE}) begin
					wl_q <= adv_line;
					wc_q <= adv_cyc;
				end
			end
			ST_FIXB: begin
				// no early move on the immediate position or at line start
				if (((wl_q != {1'b0, cur_line_q}) || (wc_q != c_plus2)) && (wc_q != 9'd0))
					wc_q <= {1'b0, wc_q[7:0] - 8'd2};
			end
			ST_FIXC: begin
				if (wc_q == {1'b0, cwbm_pkg::CYC_WRAP}) begin
					wc_q <= '0;
					wl_q <= wl_q + 10'd1;
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// output register, valid held until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_passed_q <= passed_q;
			out_found_q  <= found_q;
			out_line_q   <= wl_q[8:0];
			out_cycle_q  <= wc_q[7:0];
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.passed_now = out_passed_q;
	assign out_ch.wake_found = out_found_q;
	assign out_ch.wake_line  = out_line_q;
	assign out_ch.wake_cycle = out_cycle_q;
endmodule
`default_nettype wire

// File: hdl/cwbm_chk.sv
// port-level checker for the copper wait beam compare block, with its bind
`default_nettype none
module cwbm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       wake_found,
	input wire logic [8:0] wake_line,
	input wire logic [7:0] wake_cycle
);
	// one instruction at a time: busy right after an accepted beat
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an instruction is in flight");

	// a result appears only when the sequencer was busy before
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

	// no wakeup reports a zero position
	a_no_wake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wake_found |-> wake_line == 9'd0 && wake_cycle == 8'd0)
		else $error("wakeup position set without a wakeup");

	// a result beat waits until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");
endmodule

bind copper_wait_beam_match cwbm_chk u_cwbm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.wake_found (out_ch.wake_found),
	.wake_line  (out_ch.wake_line),
	.wake_cycle (out_ch.wake_cycle)
);
`default_nettype wire

// File: tb/beam_match_checker.sv
// beam match checker: tracks the registers, predicts each wakeup and compares the result beats
`timescale 1ns / 1ps
module beam_match_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic                         pready,
	input  wire logic [cwbm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [cwbm_pkg::PDATA_W-1:0] pwdata,
	cwbm_in_if                                in_ch,
	cwbm_out_if                               out_ch,
	output int unsigned                       fail_count,
	output int unsigned                       pending,
	output int unsigned                       items_in,
	output int unsigned                       results_out,
	output int unsigned                       wakes_found,
	output int unsigned                       skips_passed
);
	import cwbm_pkg::*;

	typedef struct packed {
		logic       passed;
		logic       found;
		logic [8:0] line;
		logic [7:0] cycle;
	} wake_t;

	int unsigned frame_lines;
	int unsigned cyc_per_line;
	wake_t       due_wakes[$];
	int unsigned fails, n_in, n_out, n_found, n_passed;

	function automatic int masked_diff(input int unsigned v, input int unsigned t,
			input int unsigned m);
		return int'(v & m) - int'(t & m);
	endfunction

	// move the beam on by n, one wrap at most, odd cycle after a wrap made even
	function automatic void step_beam(inout int unsigned ln, inout int unsigned cy,
			input int unsigned n);
		cy += n;
		if (cy >= cyc_per_line) begin
			cy -= cyc_per_line;
			ln++;
			if (cy[0])
				cy++;
		end
	endfunction

	// first cycle from cy within the line bound that reaches the horizontal target
	function automatic bit scan_cycle(inout int unsigned cy, input int unsigned th,
			input int unsigned mh);
		int unsigned c;
		c = cy;
		while (c <= cyc_per_line && masked_diff(c, th, mh) < 0)
			c += 2;
		if (c <= cyc_per_line) begin
			cy = c;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic wake_t wake_of(input logic [15:0] w1, input logic [15:0] w2,
			input logic [8:0] cur_ln, input logic [7:0] cur_cy);
		int unsigned tv, th, mv, mh, ln, cy, start_cy;
		int d;
		bit hit;
		wake_t r;
		tv = w1[15:8];
		th = w1[7:0] & 8'hfe;
		mv = w2[15:8] | 8'h80;
		mh = w2[7:0] & 8'hfe;
		start_cy = cur_cy;
		d = masked_diff(cur_ln, tv, mv);
		r.passed = (d > 0) || (d == 0 && masked_diff(start_cy, th, mh) >= 0);
		ln = cur_ln;
		cy = start_cy;
		step_beam(ln, cy, 2);
		d = masked_diff(ln, tv, mv);
		if (d > 0) begin
			hit = 1'b1;
		end else if (d == 0 && scan_cycle(cy, th, mh)) begin
			hit = 1'b1;
		end else begin
			ln++;
			cy = 0;
			if (scan_cycle(cy, th, mh)) begin
				while (ln < frame_lines && masked_diff(ln, tv, mv) < 0)
					ln++;
				if (masked_diff(ln, tv, mv) < 0)
					cy = 0;
			end else begin
				while (ln < frame_lines && masked_diff(ln, tv, mv) <= 0)
					ln++;
			end
			hit = ln < frame_lines;
		end
		if (hit) begin
			if (cy == CYC_HOLE)
				step_beam(ln, cy, 1);
			if ((ln != cur_ln || cy != start_cy + 2) && cy != 0)
				cy = (cy - 2) & 8'hff;
			if (cy == CYC_WRAP) begin
				cy = 0;
				ln++;
			end
		end else begin
			ln = 0;
			cy = 0;
		end
		r.found = hit;
		r.line  = ln[8:0];
		r.cycle = cy[7:0];
		return r;
	endfunction

	function automatic void log_fail(input string what);
		fails++;
		if (fails <= 10)
			$display("[%0t] %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wake_t got, want;
		if (!arst_n) begin
			frame_lines  = LINES_RESET;
			cyc_per_line = CYCLES_RESET;
			due_wakes.delete();
			fails    = 0;
			n_in     = 0;
			n_out    = 0;
			n_found  = 0;
			n_passed = 0;
		end else begin
			// result side first, so a beat never meets its own prediction
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.passed_now, out_ch.wake_found, out_ch.wake_line,
					out_ch.wake_cycle};
				n_out++;
				if (due_wakes.size() == 0) begin
					log_fail($sformatf("result beat %0d with nothing outstanding: %0b %0b %0d %0d",
						n_out, got.passed, got.found, got.line, got.cycle));
				end else begin
					want = due_wakes.pop_front();
					if (got.passed !== want.passed || got.found !== want.found ||
							got.line !== want.line || got.cycle !== want.cycle)
						log_fail($sformatf({"result beat %0d: expected passed %0b found %0b",
							" line %0d cycle %0d, got passed %0b found %0b line %0d cycle %0d"},
							n_out, want.passed, want.found, want.line, want.cycle,
							got.passed, got.found, got.line, got.cycle));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = wake_of(in_ch.first_word, in_ch.second_word, in_ch.current_line,
					in_ch.current_cycle);
				due_wakes.push_back(want);
				n_in++;
				n_found  += want.found;
				n_passed += want.passed;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_CYCLES)
					cyc_per_line = pwdata[CYCLE_W-1:0];
				else
					frame_lines = pwdata[LINE_W-1:0];
			end
		end
		fail_count   <= fails;
		pending      <= due_wakes.size();
		items_in     <= n_in;
		results_out  <= n_out;
		wakes_found  <= n_found;
		skips_passed <= n_passed;
	end

endmodule

// File: tb/copper_wait_beam_match_test.sv
// top of the copper wait beam match testbench: clock, reset, stimulus, back-pressure, verdict
`timescale 1ns / 1ps
module copper_wait_beam_match_test;
	import cwbm_pkg::*;

	localparam int unsigned N_PH        = 8;
	localparam int unsigned HOLD_OFF    = 3000;   // long receiver stall, well past two scans
	localparam int unsigned STALL_LIMIT = 20000;  // cycles with no beat on either channel
	localparam int unsigned DRAIN       = 800;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	cwbm_in_if  in_ch ();
	cwbm_out_if out_ch ();

	int unsigned fail_count, pending, items_in, results_out, wakes_found, skips_passed;
	int unsigned sent;
	int unsigned phase_no;
	bit          idle_on;
	bit          held_off;

	// register settings per phase: reset values, extremes, degenerate frames, random, reset again
	int unsigned ph_lines  [N_PH] = '{313, 511, 1, 0, 5, 0, 0, 313};
	int unsigned ph_cycles [N_PH] = '{227, 255, 2, 0, 1, 0, 0, 227};
	int unsigned ph_count  [N_PH] = '{150, 200, 100, 12, 12, 200, 200, 296};
	bit          ph_rand   [N_PH] = '{0, 0, 0, 0, 0, 1, 1, 0};
	// last phase runs with no idling at all
	bit          ph_idle   [N_PH] = '{1, 1, 1, 1, 1, 1, 1, 0};

	copper_wait_beam_match dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	beam_match_checker wake_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.items_in     (items_in),
		.results_out  (results_out),
		.wakes_found  (wakes_found),
		.skips_passed (skips_passed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// setup cycle then access cycle; the register takes the value at the access edge
	task automatic write_reg(input logic idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// idle the bus before returning, so back-to-back writes never touch psel twice in a step
		@(posedge clk);
	endtask

	// offer one wait/skip beat, maybe after a random gap, and hold it until taken
	task automatic send_instr(input int unsigned fw, input int unsigned sw,
			input int unsigned ln, input int unsigned cy);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.first_word    <= fw[15:0];
		in_ch.second_word   <= sw[15:0];
		in_ch.current_line  <= ln[8:0];
		in_ch.current_cycle <= cy[7:0];
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// result side: random ready with stall bursts, plus one long hold-off once the
	// widest-frame phase is offering beats, so the block fills and the input stalls
	initial begin
		out_ch.ready <= 1'b0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && phase_no == 1 && in_ch.valid) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// watchdog: too long with no beat on either channel ends the run
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("no beat for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned fw, sw, ln, cy, kind, tl, tc, lif, cil;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.first_word    <= '0;
		in_ch.second_word   <= '0;
		in_ch.current_line  <= '0;
		in_ch.current_cycle <= '0;
		arst_n              <= 1'b0;
		sent     = 0;
		phase_no = 0;
		idle_on  = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PH; p++) begin
			phase_no = p;
			idle_on  = ph_idle[p];
			if (ph_rand[p]) begin
				lif = $urandom_range(1, 511);
				cil = $urandom_range(2, 255);
			end else begin
				lif = ph_lines[p];
				cil = ph_cycles[p];
			end

			if (p > 0) begin
				// registers change only with the block idle: every beat sent has its result
				in_ch.valid <= 1'b0;
				while (pending != 0 || items_in != sent)
					@(posedge clk);
				repeat (4) @(posedge clk);
				write_reg(REG_LINES, lif);
				write_reg(REG_CYCLES, cil);
			end else begin
				// directed beats at the reset frame: 313 lines, line length 227
				send_instr(16'h0000, 16'h0000, 0, 0);        // everything zero
				send_instr(16'hffff, 16'hffff, 511, 255);    // everything at its top
				send_instr(16'h0a17, 16'hfffe, 10, 20);      // target right at cycle+2
				send_instr(16'h6433, 16'hfffe, 10, 20);      // target many lines on
				send_instr(16'h32e3, 16'hfffe, 50, 100);     // target on the hole cycle
				send_instr(16'h32e3, 16'hfffe, 50, 8'he0);   // hole reached right away
				send_instr(16'h14e1, 16'hfffe, 20, 8'hde);   // wrap cycle reached right away
				send_instr(16'h0501, 16'hfffe, 40, 60);      // target already behind the beam
				send_instr(16'hff01, 16'hfffe, 260, 30);     // target never reached in frame
				send_instr(16'h9051, 16'hfffe, 400, 20);     // match on a line past the frame
				send_instr(16'h2101, 16'hfffe, 32, 100);     // match at the start of a line
				send_instr(16'h0a41, 16'hfffe, 10, 21);      // odd beam cycle
				send_instr(16'h0c11, 16'hfffe, 11, 240);     // beam past the end of the line
				send_instr(16'h8081, 16'h0000, 5, 6);        // only the forced mask bit
				send_instr(16'h0b01, 16'hfffe, 10, 226);     // wrap lands on an odd cycle
				send_instr(16'h0b05, 16'hfffe, 10, 225);     // wrap lands on cycle zero
				send_instr(16'h0001, 16'hfffe, 255, 100);    // line 255 rolls into 256
				send_instr(16'h7ffe, 16'h7f00, 300, 128);    // vertical mask with no cycle mask
				send_instr(16'h1001, 16'h00fe, 300, 2);      // vertical compare on bit 7 alone
			end

			for (int n = 0; n < ph_count[p]; n++) begin
				fw   = $urandom_range(0, 65535);
				sw   = $urandom_range(0, 65535);
				ln   = $urandom_range(0, 511);
				cy   = $urandom_range(0, 255);
				kind = $urandom_range(0, 9);
				// kinds 0 and 1 stay fully random noise
				if (kind >= 2) begin
					// well-formed wait: beam inside frame and line on an even cycle,
					// target a little ahead so the scan has real work
					ln = (lif > 0) ? $urandom_range(0, lif - 1) : 0;
					cy = $urandom_range(0, cil) & 'hfe;
					tl = (kind == 3) ? $urandom_range(0, 255) : ln + $urandom_range(0, 40) - 2;
					tc = $urandom_range(0, cil);
					case (kind)
						7: begin
							// aim at the wrap, the hole, line start or the line end
							case ($urandom_range(0, 3))
								0: tc = CYC_WRAP;
								1: tc = CYC_HOLE;
								2: tc = 0;
								default: tc = cil;
							endcase
							if ($urandom_range(0, 1)) begin
								tl = ln;
								cy = (tc - 2 * $urandom_range(1, 3)) & 'hfe;
							end
						end
						8: begin
							// beam at the 255/256 seam or around the frame edge
							ln = $urandom_range(0, 1) ? 254 + $urandom_range(0, 3)
								: lif + $urandom_range(0, 2) - 1;
							tl = ln + $urandom_range(0, 3);
						end
						9: cy = $urandom_range(0, 255);  // odd or past the line
						default: ;
					endcase
					fw = 32'({tl[7:0], tc[7:1], fw[0]});
					// kind 6 keeps random masks, the rest compare all bits
					if (kind != 6)
						sw = 32'({sw[15], 7'h7f, 7'h7f, sw[0]});
				end
				send_instr(fw, sw, ln, cy);
			end
		end

		in_ch.valid <= 1'b0;
		while (pending != 0 || items_in != sent)
			@(posedge clk);
		// let any stray result beat show up before the verdict
		repeat (DRAIN) @(posedge clk);

		$display("ran %0d wait/skip beats over %0d register settings, with a long result stall",
			items_in, N_PH);
		$display("%0d results: %0d found a wakeup in the frame, %0d already past the target",
			results_out, wakes_found, skips_passed);
		if (pending != 0)
			$display("%0d results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
